// ----- rtl/dmfp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmfp_pkg
// Shared types and field-kind codes for the DNS message field parser.
// ----------------------------------------------------------------------------
package dmfp_pkg;

  // Field kinds carried on the result stream
  localparam logic [4:0] KIND_ID        = 5'd0;
  localparam logic [4:0] KIND_NAME_CHAR = 5'd6;
  localparam logic [4:0] KIND_NAME_SEP  = 5'd7;
  localparam logic [4:0] KIND_QTYPE     = 5'd8;
  localparam logic [4:0] KIND_QCLASS    = 5'd9;
  localparam logic [4:0] KIND_AN_PTR    = 5'd10;
  localparam logic [4:0] KIND_AN_TTL    = 5'd13;
  localparam logic [4:0] KIND_AN_RDLEN  = 5'd14;
  localparam logic [4:0] KIND_AN_IPV4   = 5'd15;
  localparam logic [4:0] KIND_END_OK    = 5'd16;
  localparam logic [4:0] KIND_END_SHORT = 5'd17;
  localparam logic [4:0] KIND_END_TRUNC = 5'd18;

  // Label separator character ('.')
  localparam logic [7:0] SEP_CHAR = 8'h2E;

  // Record type and length that carry an IPv4 address
  localparam logic [15:0] TYPE_A   = 16'd1;
  localparam logic [15:0] LEN_IPV4 = 16'd4;

  // One result item
  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] value;
    logic [15:0] index;
    logic        last;
  } res_t;

  // Up to two results caused by one input item, in order
  typedef struct packed {
    logic [1:0] vld;
    res_t       r1;
    res_t       r0;
  } res_pair_t;

endpackage
`default_nettype wire

// ----- rtl/dmfp_parse.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmfp_parse
// Parse state registers and the per-byte state update; produces up to two
// results for each accepted byte (a completed field, then an end mark).
// ----------------------------------------------------------------------------
module dmfp_parse (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic [7:0]         byte_i,
  input  wire logic               eop_i,
  output dmfp_pkg::res_pair_t     res_o
);

  localparam logic [2:0] PH_HDR   = 3'd0;
  localparam logic [2:0] PH_QLEN  = 3'd1;
  localparam logic [2:0] PH_QCHR  = 3'd2;
  localparam logic [2:0] PH_QTAIL = 3'd3;
  localparam logic [2:0] PH_ANS   = 3'd4;
  localparam logic [2:0] PH_RDATA = 3'd5;
  localparam logic [2:0] PH_DONE  = 3'd6;

  logic [2:0]  phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] shift_q, shift_d;
  logic [15:0] ans_left_q, ans_left_d;
  logic [15:0] ans_num_q, ans_num_d;
  logic [7:0]  label_left_q, label_left_d;
  logic [15:0] rtype_q, rtype_d;
  logic [15:0] rd_left_q, rd_left_d;
  logic        label_seen_q, label_seen_d;

  logic [31:0]    shift_new;
  logic [15:0]    ans_left_dec;
  logic [15:0]    rd_left_dec;
  logic [7:0]     label_dec;
  logic           f_vld;
  dmfp_pkg::res_t f_res;
  dmfp_pkg::res_t e_res;

  assign shift_new    = {shift_q[23:0], byte_i};
  assign ans_left_dec = ans_left_q - 16'd1;
  assign rd_left_dec  = rd_left_q - 16'd1;
  assign label_dec    = label_left_q - 8'd1;

  // Next state and field result
  always_comb begin
    phase_d      = phase_q;
    cnt_d        = cnt_q;
    shift_d      = shift_q;
    ans_left_d   = ans_left_q;
    ans_num_d    = ans_num_q;
    label_left_d = label_left_q;
    rtype_d      = rtype_q;
    rd_left_d    = rd_left_q;
    label_seen_d = label_seen_q;
    f_vld        = 1'b0;
    f_res        = '0;
    e_res        = '0;

    case (phase_q)
      PH_HDR: begin
        shift_d = shift_new;
        // odd byte closes a 16-bit header field
        if (cnt_q[0]) begin
          f_vld       = 1'b1;
          f_res.kind  = dmfp_pkg::KIND_ID + {2'b00, cnt_q[3:1]};
          f_res.value = {16'h0000, shift_new[15:0]};
          if (cnt_q == 4'd7) begin
            ans_left_d = shift_new[15:0];
          end
        end
        if (cnt_q >= 4'd11) begin
          phase_d      = PH_QLEN;
          cnt_d        = '0;
          label_seen_d = 1'b0;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      PH_QLEN: begin
        if (byte_i == 8'h00) begin
          phase_d = PH_QTAIL;
          cnt_d   = '0;
        end else begin
          if (label_seen_q) begin
            f_vld       = 1'b1;
            f_res.kind  = dmfp_pkg::KIND_NAME_SEP;
            f_res.value = {24'h0, dmfp_pkg::SEP_CHAR};
          end
          label_seen_d = 1'b1;
          label_left_d = byte_i;
          phase_d      = PH_QCHR;
        end
      end
      PH_QCHR: begin
        f_vld        = 1'b1;
        f_res.kind   = dmfp_pkg::KIND_NAME_CHAR;
        f_res.value  = {24'h0, byte_i};
        label_left_d = label_dec;
        if (label_dec == 8'h00) begin
          phase_d = PH_QLEN;
        end
      end
      PH_QTAIL: begin
        shift_d = shift_new;
        if (cnt_q[1:0] == 2'd1) begin
          f_vld       = 1'b1;
          f_res.kind  = dmfp_pkg::KIND_QTYPE;
          f_res.value = {16'h0000, shift_new[15:0]};
        end
        if (cnt_q[1:0] == 2'd3) begin
          f_vld       = 1'b1;
          f_res.kind  = dmfp_pkg::KIND_QCLASS;
          f_res.value = {16'h0000, shift_new[15:0]};
          ans_num_d   = '0;
          if (ans_left_q == 16'h0000) begin
            phase_d = PH_DONE;
          end else begin
            phase_d = PH_ANS;
            cnt_d   = '0;
          end
        end else begin
          cnt_d = {2'b00, cnt_q[1:0] + 2'd1};
        end
      end
      PH_ANS: begin
        shift_d     = shift_new;
        f_res.index = ans_num_q;
        if (cnt_q == 4'd1 || cnt_q == 4'd3 || cnt_q == 4'd5) begin
          f_vld       = 1'b1;
          f_res.kind  = dmfp_pkg::KIND_AN_PTR + {2'b00, cnt_q[3:1]};
          f_res.value = {16'h0000, shift_new[15:0]};
          if (cnt_q == 4'd3) begin
            rtype_d = shift_new[15:0];
          end
        end else if (cnt_q == 4'd9) begin
          f_vld       = 1'b1;
          f_res.kind  = dmfp_pkg::KIND_AN_TTL;
          f_res.value = shift_new;
        end
        if (cnt_q >= 4'd11) begin
          rd_left_d   = shift_new[15:0];
          f_vld       = 1'b1;
          f_res.kind  = dmfp_pkg::KIND_AN_RDLEN;
          f_res.value = {16'h0000, shift_new[15:0]};
          if (shift_new[15:0] == 16'h0000) begin
            // empty RDATA: answer ends here
            ans_num_d  = ans_num_q + 16'd1;
            ans_left_d = ans_left_dec;
            if (ans_left_dec == 16'h0000) begin
              phase_d = PH_DONE;
            end else begin
              phase_d = PH_ANS;
              cnt_d   = '0;
            end
          end else begin
            phase_d = PH_RDATA;
            cnt_d   = (rtype_q == dmfp_pkg::TYPE_A && shift_new[15:0] == dmfp_pkg::LEN_IPV4)
                      ? 4'd1 : 4'd0;
          end
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      PH_RDATA: begin
        shift_d   = shift_new;
        rd_left_d = rd_left_dec;
        if (rd_left_dec == 16'h0000) begin
          if (cnt_q == 4'd1) begin
            f_vld       = 1'b1;
            f_res.kind  = dmfp_pkg::KIND_AN_IPV4;
            f_res.value = shift_new;
            f_res.index = ans_num_q;
          end
          ans_num_d  = ans_num_q + 16'd1;
          ans_left_d = ans_left_dec;
          if (ans_left_dec == 16'h0000) begin
            phase_d = PH_DONE;
          end else begin
            phase_d = PH_ANS;
            cnt_d   = '0;
          end
        end
      end
      default: begin
        phase_d = PH_DONE;
      end
    endcase

    // End of packet: classify, then back to the reset state
    if (eop_i) begin
      e_res.last = 1'b1;
      if (phase_d == PH_DONE) begin
        e_res.kind = dmfp_pkg::KIND_END_OK;
      end else if (phase_d == PH_HDR) begin
        e_res.kind = dmfp_pkg::KIND_END_SHORT;
      end else begin
        e_res.kind = dmfp_pkg::KIND_END_TRUNC;
      end
      phase_d      = PH_HDR;
      cnt_d        = '0;
      shift_d      = '0;
      ans_left_d   = '0;
      ans_num_d    = '0;
      label_left_d = '0;
      rtype_d      = '0;
      rd_left_d    = '0;
      label_seen_d = 1'b0;
    end
  end

  // Results in order: field first, then end mark
  always_comb begin
    res_o.r0  = f_vld ? f_res : e_res;
    res_o.r1  = e_res;
    res_o.vld = 2'b00;
    if (accept_i) begin
      if (f_vld && eop_i) begin
        res_o.vld = 2'b11;
      end else if (f_vld || eop_i) begin
        res_o.vld = 2'b01;
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HDR;
      cnt_q        <= '0;
      shift_q      <= '0;
      ans_left_q   <= '0;
      ans_num_q    <= '0;
      label_left_q <= '0;
      rtype_q      <= '0;
      rd_left_q    <= '0;
      label_seen_q <= 1'b0;
    end else if (accept_i) begin
      phase_q      <= phase_d;
      cnt_q        <= cnt_d;
      shift_q      <= shift_d;
      ans_left_q   <= ans_left_d;
      ans_num_q    <= ans_num_d;
      label_left_q <= label_left_d;
      rtype_q      <= rtype_d;
      rd_left_q    <= rd_left_d;
      label_seen_q <= label_seen_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/dmfp_outq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmfp_outq
// Four-entry result queue: takes up to two results a cycle, hands out one while the reader is ready.
// ----------------------------------------------------------------------------
module dmfp_outq (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire dmfp_pkg::res_pair_t push_i,
  output logic                     room_o,
  output logic                     vld_o,
  input  wire logic                rdy_i,
  output dmfp_pkg::res_t           res_o
);

  dmfp_pkg::res_t mem_q [4];
  logic [1:0]     wr_ptr_q, rd_ptr_q;
  logic [2:0]     count_q;
  logic           pop;
  logic [1:0]     wr_ptr_p1;
  logic [2:0]     n_push;

  assign vld_o     = (count_q != 3'd0);
  assign pop       = vld_o && rdy_i;
  assign room_o    = (count_q <= 3'd2);
  assign res_o     = mem_q[rd_ptr_q];
  assign wr_ptr_p1 = wr_ptr_q + 2'd1;
  assign n_push    = {2'b00, push_i.vld[0]} + {2'b00, push_i.vld[1]};

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i.vld[0]) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.vld[1]) begin
      mem_q[wr_ptr_p1] <= push_i.r1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + n_push[1:0];
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      count_q <= count_q + n_push - {2'b00, pop};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/dns_message_field_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dns_message_field_parser
// Streams a DNS payload byte by byte and emits header, question and answer
// fields as they complete.
// ----------------------------------------------------------------------------
// Each result is written into the result queue as the byte that causes it is accepted.
// One byte per cycle while input ready is high; a byte that yields two results (field
// plus end mark) puts both into a 4-entry result queue, which hands them out in order.
// Input ready drops only while the result queue holds more than two items.
// Reset (rst_ni low, asynchronous) returns the parser to the header phase
// and empties the result queue.
module dns_message_field_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  wire logic        s_axis_tlast,  // end_of_packet
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // [31:0] field_value, [47:32] answer_index
  output logic [4:0]       m_axis_tuser,  // [4:0] field_kind
  output logic             m_axis_tlast   // last_of_packet
);

  logic                accept;
  dmfp_pkg::res_pair_t res_pair;
  dmfp_pkg::res_t      head;

  assign accept = s_axis_tvalid && s_axis_tready;

  dmfp_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .eop_i    (s_axis_tlast),
    .res_o    (res_pair)
  );

  dmfp_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_pair),
    .room_o (s_axis_tready),
    .vld_o  (m_axis_tvalid),
    .rdy_i  (m_axis_tready),
    .res_o  (head)
  );

  // Output packing
  assign m_axis_tdata = {head.index, head.value};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule
`default_nettype wire

// ----- tb/sv/dns_message_field_parser_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_message_field_parser_tb
// Self-checking bench for the DNS field parser. DNS payloads are streamed in
// byte by byte with random gaps. A behavioral parser in the bench predicts
// every field and end mark. Each result is compared in order with the
// prediction while the result side stalls at random, with one long hold.
// ----------------------------------------------------------------------------
module dns_message_field_parser_tb;

  localparam int  CLK_HALF      = 6;
  localparam int  RESET_CYCLES  = 8;
  localparam int  RANDOM_BYTES  = 1600;
  localparam int  DRAIN_CYCLES  = 8;
  localparam int  CYCLE_LIMIT   = 1000000;
  localparam int  MAX_PRINTED   = 40;

  // Parser phases of the behavioral model
  typedef enum logic [3:0] {
    P_HEADER, P_LABEL_LEN, P_LABEL_CHAR, P_QUESTION_TAIL, P_ANSWER, P_RDATA, P_DONE
  } parse_phase_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;  // [31:0] field_value, [47:32] answer_index
  logic [4:0]  m_axis_tuser;  // [4:0] field_kind
  logic        m_axis_tlast;

  dns_message_field_parser i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Bench bookkeeping
  dmfp_pkg::res_t expected_fields[$];
  logic [7:0]  pkt[$];
  int          mismatch_count = 0;
  int          bytes_sent     = 0;
  int unsigned cycle_count    = 0;
  bit          tx_gaps_on     = 1'b1;
  bit          rx_stalls_on   = 1'b1;
  int          hold_len       = 0;
  int          hold_req_id    = 0;

  // Behavioral parser state
  parse_phase_e phase       = P_HEADER;
  logic [3:0]   byte_cnt    = '0;
  logic [31:0]  shift_reg   = '0;
  logic [15:0]  answers_left = '0;
  logic [15:0]  answer_num  = '0;
  logic [7:0]   label_left  = '0;
  logic [15:0]  record_type = '0;
  logic [15:0]  rdata_left  = '0;
  logic         label_seen  = 1'b0;

  // --------------------------------------------------------------------------
  // Field predictor
  // --------------------------------------------------------------------------
  function automatic void push_field(logic [4:0] k, logic [31:0] v, logic [15:0] idx,
                                     logic last);
    dmfp_pkg::res_t r;
    r.kind  = k;
    r.value = v;
    r.index = idx;
    r.last  = last;
    expected_fields.push_back(r);
  endfunction

  function automatic void reset_parser();
    phase        = P_HEADER;
    byte_cnt     = '0;
    shift_reg    = '0;
    answers_left = '0;
    answer_num   = '0;
    label_left   = '0;
    record_type  = '0;
    rdata_left   = '0;
    label_seen   = 1'b0;
  endfunction

  function automatic void next_answer_or_done();
    if (answers_left == 16'd0) begin
      phase = P_DONE;
    end else begin
      phase    = P_ANSWER;
      byte_cnt = '0;
    end
  endfunction

  function automatic void close_answer();
    answer_num   = answer_num + 16'd1;
    answers_left = answers_left - 16'd1;
    next_answer_or_done();
  endfunction

  function automatic void predict_fields(logic [7:0] b, logic eop);
    logic [3:0] c;
    case (phase)
      P_HEADER: begin
        shift_reg = {shift_reg[23:0], b};
        c = byte_cnt;
        if (c[0]) begin
          push_field(dmfp_pkg::KIND_ID + {2'b00, c[3:1]}, {16'h0, shift_reg[15:0]}, '0,
                     1'b0);
          if (c == 4'd7) answers_left = shift_reg[15:0];
        end
        if (c >= 4'd11) begin
          phase      = P_LABEL_LEN;
          byte_cnt   = '0;
          label_seen = 1'b0;
        end else begin
          byte_cnt = c + 4'd1;
        end
      end
      P_LABEL_LEN: begin
        if (b == 8'd0) begin
          phase    = P_QUESTION_TAIL;
          byte_cnt = '0;
        end else begin
          if (label_seen)
            push_field(dmfp_pkg::KIND_NAME_SEP, {24'h0, dmfp_pkg::SEP_CHAR}, '0, 1'b0);
          label_seen = 1'b1;
          label_left = b;
          phase      = P_LABEL_CHAR;
        end
      end
      P_LABEL_CHAR: begin
        push_field(dmfp_pkg::KIND_NAME_CHAR, {24'h0, b}, '0, 1'b0);
        label_left = label_left - 8'd1;
        if (label_left == 8'd0) phase = P_LABEL_LEN;
      end
      P_QUESTION_TAIL: begin
        shift_reg = {shift_reg[23:0], b};
        c = byte_cnt & 4'd3;
        if (c == 4'd1)
          push_field(dmfp_pkg::KIND_QTYPE, {16'h0, shift_reg[15:0]}, '0, 1'b0);
        if (c == 4'd3) begin
          push_field(dmfp_pkg::KIND_QCLASS, {16'h0, shift_reg[15:0]}, '0, 1'b0);
          answer_num = '0;
          next_answer_or_done();
        end else begin
          byte_cnt = c + 4'd1;
        end
      end
      P_ANSWER: begin
        shift_reg = {shift_reg[23:0], b};
        c = byte_cnt;
        if (c == 4'd1 || c == 4'd3 || c == 4'd5) begin
          push_field(dmfp_pkg::KIND_AN_PTR + {2'b00, c[3:1]}, {16'h0, shift_reg[15:0]},
                     answer_num, 1'b0);
          if (c == 4'd3) record_type = shift_reg[15:0];
        end else if (c == 4'd9) begin
          push_field(dmfp_pkg::KIND_AN_TTL, shift_reg, answer_num, 1'b0);
        end
        if (c >= 4'd11) begin
          rdata_left = shift_reg[15:0];
          push_field(dmfp_pkg::KIND_AN_RDLEN, {16'h0, rdata_left}, answer_num, 1'b0);
          if (rdata_left == 16'd0) begin
            close_answer();
          end else begin
            phase    = P_RDATA;
            byte_cnt = (record_type == dmfp_pkg::TYPE_A && rdata_left == dmfp_pkg::LEN_IPV4)
                       ? 4'd1 : 4'd0;
          end
        end else begin
          byte_cnt = c + 4'd1;
        end
      end
      P_RDATA: begin
        shift_reg  = {shift_reg[23:0], b};
        rdata_left = rdata_left - 16'd1;
        if (rdata_left == 16'd0) begin
          if (byte_cnt == 4'd1)
            push_field(dmfp_pkg::KIND_AN_IPV4, shift_reg, answer_num, 1'b0);
          close_answer();
        end
      end
      default: phase = P_DONE;
    endcase

    // End mark closes the packet
    if (eop) begin
      if (phase == P_DONE)
        push_field(dmfp_pkg::KIND_END_OK, '0, '0, 1'b1);
      else if (phase == P_HEADER)
        push_field(dmfp_pkg::KIND_END_SHORT, '0, '0, 1'b1);
      else
        push_field(dmfp_pkg::KIND_END_TRUNC, '0, '0, 1'b1);
      reset_parser();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Packet building
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void put16(logic [15:0] v);
    pkt.push_back(v[15:8]);
    pkt.push_back(v[7:0]);
  endfunction

  function automatic void put_header(logic [15:0] id, logic [15:0] flags, logic [15:0] qd,
                                     logic [15:0] an, logic [15:0] ns, logic [15:0] ar);
    put16(id);
    put16(flags);
    put16(qd);
    put16(an);
    put16(ns);
    put16(ar);
  endfunction

  function automatic void put_label(string s);
    pkt.push_back(8'(s.len()));
    for (int i = 0; i < s.len(); i++) pkt.push_back(s.getc(i));
  endfunction

  // Fixed part of one answer followed by len random rdata bytes
  function automatic void put_answer(logic [15:0] ptr, logic [15:0] typ, logic [15:0] cls,
                                     logic [31:0] ttl, logic [15:0] len);
    put16(ptr);
    put16(typ);
    put16(cls);
    put16(ttl[31:16]);
    put16(ttl[15:0]);
    put16(len);
    repeat (len) pkt.push_back(8'($urandom));
  endfunction

  function automatic void put_random_name();
    int len;
    repeat ($urandom_range(0, 4)) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 255) : $urandom_range(1, 15);
      pkt.push_back(8'(len));
      repeat (len) pkt.push_back(8'($urandom));
    end
    pkt.push_back(8'h00);
  endfunction

  function automatic void put_random_answer();
    logic [15:0] ptr, typ, len;
    ptr = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'hC00C;
    typ = ($urandom_range(0, 1) == 0) ? dmfp_pkg::TYPE_A : 16'($urandom);
    if ($urandom_range(0, 19) == 0)
      len = 16'($urandom_range(9, 40));
    else if (typ == dmfp_pkg::TYPE_A)
      len = ($urandom_range(0, 4) != 0) ? dmfp_pkg::LEN_IPV4 : 16'($urandom_range(0, 8));
    else
      len = ($urandom_range(0, 2) == 0) ? dmfp_pkg::LEN_IPV4 : 16'($urandom_range(0, 8));
    put_answer(ptr, typ, 16'($urandom), $urandom, len);
  endfunction

  function automatic void cut_packet(int n);
    if (n < pkt.size()) pkt = pkt[0:n-1];
  endfunction

  // --------------------------------------------------------------------------
  // Sending and draining
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic eop);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eop;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_fields(b, eop);
    bytes_sent++;
  endtask

  // Sends the built packet with tlast on its final byte, then clears it
  task automatic send_packet();
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
    pkt.delete();
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_fields.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < MAX_PRINTED)
      $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : check_results
    dmfp_pkg::res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_fields.size() == 0) begin
        report_mismatch("unexpected result, kind", {27'h0, m_axis_tuser}, '0);
      end else begin
        want = expected_fields.pop_front();
        if (m_axis_tuser != want.kind)
          report_mismatch("field_kind", {27'h0, m_axis_tuser}, {27'h0, want.kind});
        if (m_axis_tdata[31:0] != want.value)
          report_mismatch("field_value", m_axis_tdata[31:0], want.value);
        if (m_axis_tdata[47:32] != want.index)
          report_mismatch("answer_index", {16'h0, m_axis_tdata[47:32]}, {16'h0, want.index});
        if (m_axis_tlast != want.last)
          report_mismatch("last_of_packet", {31'h0, m_axis_tlast}, {31'h0, want.last});
      end
    end
  end

  // Result-side ready: random stalls plus a long hold on request
  always @(posedge clk_i) begin : drive_result_ready
    static int hold_seen_id = 0;
    static int hold_left    = 0;
    static int stall_left   = 0;
    logic rdy;
    rdy = 1'b1;
    if (hold_req_id != hold_seen_id) begin
      hold_seen_id = hold_req_id;
      hold_left    = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
      rdy = 1'b0;
    end
    m_axis_tready <= rdy;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Packets that end inside the header
  task automatic test_short_header();
    pkt.push_back(8'hFF);
    send_packet();
    put16(16'hA5A5);
    send_packet();
    repeat (11) pkt.push_back(8'h00);
    send_packet();
    wait_drained();
  endtask

  // Header of all ones and all zeros, ending right after ARCOUNT
  task automatic test_header_extremes();
    put_header('1, '1, '1, '1, '1, '1);
    send_packet();
    put_header('0, '0, '0, '0, '0, '0);
    send_packet();
    wait_drained();
  endtask

  // No answers: name with separators, root name, trailing bytes
  task automatic test_question_only();
    put_header(16'h0102, 16'h0100, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
    put_label("ab");
    put_label("c");
    pkt.push_back(8'h00);
    put16(dmfp_pkg::TYPE_A);
    put16(16'h0001);
    send_packet();
    put_header(16'hFFFF, 16'h8000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
    pkt.push_back(8'h00);
    put16(16'hFFFF);
    put16(16'hFFFF);
    repeat (3) pkt.push_back(8'($urandom));
    send_packet();
    wait_drained();
  endtask

  // Address record, zero length, non-address with length 4, address type length 3
  task automatic test_answer_records();
    put_header(16'h1234, 16'h8180, 16'h0001, 16'h0004, 16'h0000, 16'h0000);
    put_label("www");
    put_label("ex");
    pkt.push_back(8'h00);
    put16(dmfp_pkg::TYPE_A);
    put16(16'h0001);
    put_answer(16'hC00C, dmfp_pkg::TYPE_A, 16'h0001, 32'hFFFF_FFFF, dmfp_pkg::LEN_IPV4);
    put_answer(16'hFFFF, dmfp_pkg::TYPE_A, 16'hFFFF, 32'h0000_0000, 16'h0000);
    put_answer(16'h0000, 16'h001C, 16'h0000, 32'h8000_0001, dmfp_pkg::LEN_IPV4);
    put_answer(16'hC00C, dmfp_pkg::TYPE_A, 16'h0001, 32'h0000_0E10, 16'h0003);
    send_packet();
    wait_drained();
  endtask

  // One answer, cut in the name, question tail, answer fixed part and rdata, and once whole
  task automatic test_truncated_body();
    int cuts[6] = '{13, 15, 18, 25, 34, 36};
    foreach (cuts[i]) begin
      put_header(16'($urandom), 16'($urandom), 16'h0001, 16'h0001, 16'h0000, 16'h0000);
      put_label("ab");
      pkt.push_back(8'h00);
      put16(dmfp_pkg::TYPE_A);
      put16(16'h0001);
      put_answer(16'hC00C, dmfp_pkg::TYPE_A, 16'h0001, $urandom, dmfp_pkg::LEN_IPV4);
      cut_packet(cuts[i]);
      send_packet();
    end
    wait_drained();
  endtask

  // Result side held off while the sender keeps offering bytes
  task automatic test_output_hold();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    hold_len     = 300;
    hold_req_id++;
    put_header(16'($urandom), 16'($urandom), 16'h0001, 16'h0002, 16'h0000, 16'h0000);
    put_label("hold");
    put_label("test");
    pkt.push_back(8'h00);
    put16(dmfp_pkg::TYPE_A);
    put16(16'h0001);
    put_answer(16'hC00C, dmfp_pkg::TYPE_A, 16'h0001, $urandom, dmfp_pkg::LEN_IPV4);
    put_answer(16'hC00C, 16'h0005, 16'h0001, $urandom, 16'h0006);
    send_packet();
    wait_drained();
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // Mostly well-formed packets with random content, some cut short, some noise
  task automatic test_random_traffic();
    int start_bytes, an, kind_sel;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      tx_gaps_on   = ($urandom_range(0, 3) != 0);
      rx_stalls_on = ($urandom_range(0, 3) != 0);
      kind_sel     = $urandom_range(0, 99);
      if (kind_sel < 10) begin
        repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom));
      end else begin
        an = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 4);
        put_header(16'($urandom), 16'($urandom), 16'($urandom), 16'(an),
                   16'($urandom), 16'($urandom));
        put_random_name();
        put16(16'($urandom));
        put16(16'($urandom));
        repeat ((an > 4) ? 4 : an) put_random_answer();
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom));
        if (kind_sel < 30) cut_packet($urandom_range(1, pkt.size()));
      end
      send_packet();
    end
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_short_header();
    test_header_extremes();
    test_question_only();
    test_answer_records();
    test_truncated_body();
    test_output_hold();
    test_random_traffic();

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
